// ===== rtl/hsa_pkg.sv =====
// ----------------------------------------------------------------------------
// hsa_pkg
// shared types and constants for the handle slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package hsa_pkg;

	// operation codes
	localparam logic [1:0] FUNC_CREATE  = 2'd0;
	localparam logic [1:0] FUNC_DESTROY = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP  = 2'd2;

	// free stack geometry
	localparam int STACK_AW    = 16;
	localparam int STACK_DEPTH = 65536;
	localparam int COUNT_W     = STACK_AW + 1;
	localparam int ENTRY_W     = 16;

	// handle and address geometry
	localparam int          HANDLE_W    = 24;
	localparam logic [31:0] HANDLE_MASK = 32'h00FF_FFFF;
	localparam int          DESC_SHIFT  = 6;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // latch request word
		logic exec;   // decide, touch stack and counters
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/hsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// hsa_ctrl
// sequencing state machine: accept, execute, respond
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output      logic          busy,
	output      logic          done,
	output      hsa_pkg::cmd_t cmd
);

	hsa_pkg::state_t state_q, state_d;
	logic            accept;

	assign busy   = (state_q == hsa_pkg::ST_EXEC);
	assign done   = (state_q == hsa_pkg::ST_RESP);
	assign accept = start && !busy;

	assign cmd.load = accept;
	assign cmd.exec = busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hsa_pkg::ST_IDLE: if (accept) state_d = hsa_pkg::ST_EXEC;
			hsa_pkg::ST_EXEC: state_d = hsa_pkg::ST_RESP;
			hsa_pkg::ST_RESP: state_d = accept ? hsa_pkg::ST_EXEC : hsa_pkg::ST_IDLE;
			default:          state_d = hsa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hsa_datapath.sv =====
// ----------------------------------------------------------------------------
// hsa_datapath
// request latch, free stack memory, counters and result formatting
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_datapath #(
	parameter int SLOT_COUNT = 65536
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hsa_pkg::cmd_t cmd,
	input  wire logic [1:0]    func,
	input  wire logic [31:0]   handle_raw,
	input  wire logic          cfg_we,
	input  wire logic [31:0]   cfg_wdata,
	output      logic          ok,
	output      logic [15:0]   handle_out,
	output      logic [31:0]   descriptor_address,
	output      logic          stack_overflow
);

	localparam int NU_W = $clog2(SLOT_COUNT + 1);
	localparam int HW   = hsa_pkg::HANDLE_W;

	// configuration and allocator state
	logic [31:0]                  table_base_q;
	logic [NU_W-1:0]              next_unused_q;
	logic [hsa_pkg::COUNT_W-1:0]  free_count_q;

	// latched request word
	logic [1:0]    func_q;
	logic [HW-1:0] h_q;

	// free stack
	logic [hsa_pkg::ENTRY_W-1:0]  stack_mem [hsa_pkg::STACK_DEPTH];
	logic [hsa_pkg::ENTRY_W-1:0]  rd_q;
	logic                         mem_we, mem_re;
	logic [hsa_pkg::STACK_AW-1:0] mem_wa, mem_ra;

	// result registers
	logic          res_ok_q, res_pop_q, res_ovf_q;
	logic [HW-1:0] res_idx_q;

	// execute decisions
	logic          base_nz, h_valid, stack_empty, stack_full, fresh_ok;
	logic          do_pop, do_fresh, do_push;
	logic          ok_d, ovf_d;
	logic [HW-1:0] idx_d;
	logic [24:0]   nu_ext;

	assign base_nz     = (table_base_q != 32'd0);
	assign h_valid     = base_nz && (h_q != '0) && ({1'b0, h_q} < 25'(SLOT_COUNT));
	assign stack_empty = (free_count_q == '0);
	assign stack_full  = free_count_q[hsa_pkg::COUNT_W-1];
	assign fresh_ok    = (next_unused_q < NU_W'(SLOT_COUNT));
	assign nu_ext      = 25'(next_unused_q);

	always_comb begin
		do_pop   = 1'b0;
		do_fresh = 1'b0;
		do_push  = 1'b0;
		ok_d     = 1'b0;
		ovf_d    = 1'b0;
		idx_d    = h_q;
		unique case (func_q)
			hsa_pkg::FUNC_CREATE: begin
				if (base_nz && !stack_empty) begin
					do_pop = 1'b1;
					ok_d   = 1'b1;
				end else if (base_nz && fresh_ok) begin
					do_fresh = 1'b1;
					ok_d     = 1'b1;
					idx_d    = nu_ext[HW-1:0];
				end
			end
			hsa_pkg::FUNC_DESTROY: begin
				if (h_valid) begin
					ok_d    = 1'b1;
					do_push = !stack_full;
					ovf_d   = stack_full;
				end
			end
			hsa_pkg::FUNC_LOOKUP: ok_d = h_valid;
			default:              ok_d = 1'b0;
		endcase
	end

	assign mem_we = cmd.exec && do_push;
	assign mem_re = cmd.exec && do_pop;
	assign mem_wa = free_count_q[hsa_pkg::STACK_AW-1:0];
	assign mem_ra = mem_wa - 1'b1;

	always_ff @(posedge clk) begin
		if (mem_we) stack_mem[mem_wa] <= h_q[hsa_pkg::ENTRY_W-1:0];
		if (mem_re) rd_q <= stack_mem[mem_ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			h_q    <= HW'(handle_raw & hsa_pkg::HANDLE_MASK);
		end
		if (cmd.exec) begin
			res_pop_q <= do_pop;
			res_ovf_q <= ovf_d;
			res_idx_q <= idx_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q  <= 32'd0;
			next_unused_q <= NU_W'(1);
			free_count_q  <= '0;
			res_ok_q      <= 1'b0;
		end else begin
			if (cfg_we) table_base_q <= cfg_wdata;
			if (cmd.exec) begin
				res_ok_q <= ok_d;
				if (do_fresh) next_unused_q <= next_unused_q + 1'b1;
				if (do_pop)   free_count_q  <= free_count_q - 1'b1;
				if (do_push)  free_count_q  <= free_count_q + 1'b1;
			end
		end
	end

	// result formatting: popped entry or latched index, then base + handle*64
	logic [HW-1:0] hsel;
	logic [31:0]   offset;

	assign hsel   = res_pop_q ? HW'(rd_q) : res_idx_q;
	assign offset = 32'(hsel) << hsa_pkg::DESC_SHIFT;

	assign ok                 = res_ok_q;
	assign handle_out         = res_ok_q ? hsel[15:0] : 16'd0;
	assign descriptor_address = res_ok_q ? (table_base_q + offset) : 32'd0;
	assign stack_overflow     = res_ok_q && res_ovf_q;

endmodule

`default_nettype wire

// ===== rtl/handle_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// handle_slot_allocator_top
// one-based slot handle allocator with free stack and address lookup
// ----------------------------------------------------------------------------
// A request word (func, handle_raw) is taken when start is high and busy is
// low. Its result shows on ok, handle_out, descriptor_address and
// stack_overflow for exactly one cycle while done is high; the receiver
// must take it then, there is no hold-off. busy is high only in the execute
// cycle, so a new word can be issued in the cycle that shows the previous
// result. The popped handle is a registered read of the free stack memory,
// followed by the address add. The table base is written through cfg_we /
// cfg_wdata; the user must do this only while no word is in flight, which
// the block does not enforce. No clearing pass is needed after reset: only
// stack entries below the fill count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_slot_allocator_top #(
	parameter int SLOT_COUNT = 65536   // legal range 2 .. 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request word
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] handle_raw,
	// arena base register write
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	// result word, one cycle strobe
	output      logic        done,
	output      logic        ok,
	output      logic [15:0] handle_out,
	output      logic [31:0] descriptor_address,
	output      logic        stack_overflow
);

	// commands from sequencer to datapath
	hsa_pkg::cmd_t cmd;

	// idle -> execute -> respond, respond may overlap the next accept
	hsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// free stack, counters, base register and address formation
	hsa_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.func               (func),
		.handle_raw         (handle_raw),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.ok                 (ok),
		.handle_out         (handle_out),
		.descriptor_address (descriptor_address),
		.stack_overflow     (stack_overflow)
	);

endmodule

`default_nettype wire

// ===== rtl/hsa_checker.sv =====
// ----------------------------------------------------------------------------
// hsa_checker
// port level checks for the handle slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        ok,
	input wire logic [15:0] handle_out,
	input wire logic [31:0] descriptor_address,
	input wire logic        stack_overflow
);

	// an accepted word always enters execute
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// execute is always followed by exactly one result strobe
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("execute cycle not followed by result");

	// a result never appears without a word in flight
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without prior execute");

	// failures carry all-zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> handle_out == 16'd0 && descriptor_address == 32'd0
			&& !stack_overflow)
		else $error("failed result with nonzero fields");

	// a dropped push is only reported on a successful destroy
	a_ovf_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && stack_overflow |-> ok)
		else $error("overflow flagged on failed result");

endmodule

bind handle_slot_allocator_top hsa_checker u_hsa_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.start              (start),
	.busy               (busy),
	.done               (done),
	.ok                 (ok),
	.handle_out         (handle_out),
	.descriptor_address (descriptor_address),
	.stack_overflow     (stack_overflow)
);

`default_nettype wire
